// ----- rtl/crps_pkg.sv -----
// Shared types and constants for the corner response pixel stream block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package crps_pkg;

    localparam int unsigned SCALE       = 160000;
    localparam logic [34:0] SCALE_SQ    = 35'd25600000000;
    localparam logic [11:0] RESP_MAX    = 12'd4095;
    localparam int unsigned BORDER      = 5;
    localparam int unsigned DIM_FLOOR   = 11;
    localparam int unsigned DIV_STEPS   = 12;
    localparam int unsigned MUL_BITS    = 36;
    localparam int unsigned HSUM_W      = 97;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MIN_EIGEN    = 2'd2;
    localparam logic [1:0] REG_RESP_DIV     = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WIN,
        S_GRAD,
        S_PROD,
        S_HSUM,
        S_SUM,
        S_DECIDE,
        S_PREP,
        S_MSTART,
        S_MWAIT,
        S_CMP,
        S_DIVINIT,
        S_DIV,
        S_FIN,
        S_LOAD
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_WIN,
        OP_GRAD,
        OP_PROD,
        OP_HSUM,
        OP_SUM,
        OP_PREP,
        OP_MUL_START,
        OP_MUL_STORE,
        OP_CMP,
        OP_DIVINIT,
        OP_DIV_STEP,
        OP_FIN,
        OP_LOAD
    } dp_op_t;

    typedef enum logic [2:0] {
        MUL_AD,
        MUL_BB,
        MUL_TRTS,
        MUL_TSTS,
        MUL_DIV
    } mul_sel_t;

    typedef struct packed {
        dp_op_t   op;
        mul_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic pending_zero;
        logic emit;
        logic interior;
        logic mul_busy;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/crps_mul.sv -----
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on crps_pkg for the operand width.
`timescale 1ns / 1ps

module crps_mul (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [crps_pkg::MUL_BITS-1:0]   op_a,
    input  logic [crps_pkg::MUL_BITS-1:0]   op_b,
    output logic                            busy,
    output logic [2*crps_pkg::MUL_BITS-1:0] product
);
    import crps_pkg::*;

    localparam int CNT_W = $clog2(MUL_BITS + 1);

    logic                    run_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [2*MUL_BITS-1:0]   mcand_reg;
    logic [MUL_BITS-1:0]     mplier_reg;
    logic [2*MUL_BITS-1:0]   acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            cnt_reg <= CNT_W'(MUL_BITS);
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= (2*MUL_BITS)'(op_a);
            mplier_reg <= op_b;
            acc_reg    <= '0;
        end
        else if (run_reg)
        begin
            if (mplier_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign busy    = run_reg;
    assign product = acc_reg;

endmodule

// ----- rtl/crps_datapath.sv -----
// Datapath: line stores, Sobel and smoothing windows, structure matrix test,
// divider steps and the output register. Depends on crps_pkg and crps_mul.
`timescale 1ns / 1ps

module crps_datapath #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  crps_pkg::dp_cmd_t    cmd,
    output crps_pkg::dp_status_t status,
    input  logic                 in_flush,
    input  logic [11:0]          in_pixel,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [10:0]          out_row,
    output logic [10:0]          out_column,
    output logic [11:0]          response,
    output logic                 frame_end
);
    import crps_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int DW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = $clog2(3 * MAX_WIDTH + 4);
    localparam int W_RESET = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int H_RESET = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

    function automatic int clamp_dim(input logic [11:0] v, input int top);
        int r;
        r = int'(v);
        if (r < int'(DIM_FLOOR))
            r = int'(DIM_FLOOR);
        else if (r > top)
            r = top;
        return r;
    endfunction

    // configuration
    logic [DW-1:0] w_reg;
    logic [HW-1:0] h_reg;
    logic [15:0]   thr_reg;
    logic [31:0]   div_reg;

    // positions
    logic [CW-1:0] col_reg, tcol_reg, col_adv, tcol_adv;
    logic [RW-1:0] row_reg, trow_reg, row_adv, trow_adv;
    logic [PW-1:0] pend_reg, lag;

    // memories
    logic [11:0]        pix1_mem [MAX_WIDTH];
    logic [11:0]        pix2_mem [MAX_WIDTH];
    logic [HSUM_W-1:0]  hs0_mem  [MAX_WIDTH];
    logic [HSUM_W-1:0]  hs1_mem  [MAX_WIDTH];
    logic [HSUM_W-1:0]  hs2_mem  [MAX_WIDTH];
    logic [HSUM_W-1:0]  hs3_mem  [MAX_WIDTH];
    logic [11:0]        up1_reg, up2_reg, pix_reg;
    logic [HSUM_W-1:0]  rs_reg [4];

    // windows and filter stages
    logic [11:0]         pw_reg [3][3];
    logic signed [14:0]  gx_reg, gy_reg;
    logic [27:0]         pxx_reg [5];
    logic [27:0]         pyy_reg [5];
    logic signed [28:0]  pxy_reg [5];
    logic [31:0]         hxx_reg, hyy_reg;
    logic signed [32:0]  hxy_reg;
    logic [34:0]         sxx_reg, syy_reg;
    logic signed [35:0]  sxy_reg;
    logic                emit_reg, interior_reg;

    // eigenvalue test and division
    logic [34:0]  a_reg, d_reg, bm_reg;
    logic [35:0]  tr_reg;
    logic [33:0]  ts_reg;
    logic [69:0]  ad_reg, det_reg, trts_reg, rem_reg;
    logic [67:0]  tsts_reg;
    logic [66:0]  dd_reg;
    logic [78:0]  dsh_reg;
    logic [11:0]  q_reg;
    logic         ok_reg, sat_reg;

    // result and output registers
    logic [10:0]  res_row_reg, res_col_reg;
    logic [11:0]  res_resp_reg;
    logic         res_end_reg;
    logic         ov_reg;
    logic [10:0]  orow_reg, ocol_reg;
    logic [11:0]  oresp_reg;
    logic         oend_reg;

    // combinational
    logic signed [14:0] e [3][3];
    logic signed [14:0] gx_w, gy_w;
    logic signed [29:0] gxx_w, gyy_w, gxy_w;
    logic [31:0]        hxx_w, hyy_w;
    logic signed [32:0] hxy_w;
    logic [34:0]        sxx_w, syy_w;
    logic signed [35:0] sxy_w;
    logic               interior_w, tend_w;
    logic [31:0]        dvx;
    logic [MUL_BITS-1:0]   mul_a, mul_b;
    logic [2*MUL_BITS-1:0] mul_p;
    logic                  mul_busy;
    logic [70:0]        rhs_w;

    assign lag = PW'(3 * int'(w_reg) + 3);
    assign dvx = (div_reg == 32'd0) ? 32'd1 : div_reg;

    always_comb
    begin
        col_adv = col_reg + 1'b1;
        row_adv = row_reg;
        if (int'(col_reg) + 1 >= int'(w_reg))
        begin
            col_adv = '0;
            row_adv = (int'(row_reg) + 1 >= int'(h_reg)) ? '0 : row_reg + 1'b1;
        end
        tcol_adv = tcol_reg + 1'b1;
        trow_adv = trow_reg;
        if (int'(tcol_reg) + 1 >= int'(w_reg))
        begin
            tcol_adv = '0;
            trow_adv = (int'(trow_reg) + 1 >= int'(h_reg)) ? '0 : trow_reg + 1'b1;
        end
        interior_w = (int'(trow_reg) >= int'(BORDER))
                  && (int'(trow_reg) < int'(h_reg) - int'(BORDER))
                  && (int'(tcol_reg) >= int'(BORDER))
                  && (int'(tcol_reg) < int'(w_reg) - int'(BORDER));
        tend_w = (int'(trow_reg) == int'(h_reg) - 1) && (int'(tcol_reg) == int'(w_reg) - 1);
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++)
                e[k][j] = $signed(15'(pw_reg[k][j]));
        gx_w = (e[0][2] - e[0][0]) + (e[1][2] - e[1][0]) * 15'sd2 + (e[2][2] - e[2][0]);
        gy_w = (e[2][0] - e[0][0]) + (e[2][1] - e[0][1]) * 15'sd2 + (e[2][2] - e[0][2]);
        gxx_w = 30'(gx_reg) * 30'(gx_reg);
        gyy_w = 30'(gy_reg) * 30'(gy_reg);
        gxy_w = 30'(gx_reg) * 30'(gy_reg);
        hxx_w = 32'(pxx_reg[0]) + (32'(pxx_reg[1]) << 1) + (32'(pxx_reg[2]) << 2)
              + (32'(pxx_reg[3]) << 1) + 32'(pxx_reg[4]);
        hyy_w = 32'(pyy_reg[0]) + (32'(pyy_reg[1]) << 1) + (32'(pyy_reg[2]) << 2)
              + (32'(pyy_reg[3]) << 1) + 32'(pyy_reg[4]);
        hxy_w = 33'(pxy_reg[0]) + 33'(pxy_reg[1]) * 2 + 33'(pxy_reg[2]) * 4
              + 33'(pxy_reg[3]) * 2 + 33'(pxy_reg[4]);
        sxx_w = 35'(rs_reg[3][31:0]) + (35'(rs_reg[2][31:0]) << 1)
              + (35'(rs_reg[1][31:0]) << 2) + (35'(rs_reg[0][31:0]) << 1) + 35'(hxx_reg);
        syy_w = 35'(rs_reg[3][63:32]) + (35'(rs_reg[2][63:32]) << 1)
              + (35'(rs_reg[1][63:32]) << 2) + (35'(rs_reg[0][63:32]) << 1) + 35'(hyy_reg);
        sxy_w = 36'($signed(rs_reg[3][96:64])) + 36'($signed(rs_reg[2][96:64])) * 2
              + 36'($signed(rs_reg[1][96:64])) * 4 + 36'($signed(rs_reg[0][96:64])) * 2
              + 36'(hxy_reg);
        rhs_w = 71'(tsts_reg) + 71'(det_reg);
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.sel)
            MUL_AD:
            begin
                mul_a = MUL_BITS'(a_reg);
                mul_b = MUL_BITS'(d_reg);
            end
            MUL_BB:
            begin
                mul_a = MUL_BITS'(bm_reg);
                mul_b = MUL_BITS'(bm_reg);
            end
            MUL_TRTS:
            begin
                mul_a = MUL_BITS'(tr_reg);
                mul_b = MUL_BITS'(ts_reg);
            end
            MUL_TSTS:
            begin
                mul_a = MUL_BITS'(ts_reg);
                mul_b = MUL_BITS'(ts_reg);
            end
            MUL_DIV:
            begin
                mul_a = MUL_BITS'(dvx);
                mul_b = MUL_BITS'(SCALE_SQ);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    crps_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.op == OP_MUL_START),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .busy    (mul_busy),
        .product (mul_p)
    );

    // control state: configuration, positions, windows, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg    <= DW'(W_RESET);
            h_reg    <= HW'(H_RESET);
            thr_reg  <= 16'd2000;
            div_reg  <= 32'd1000000;
            col_reg  <= '0;
            row_reg  <= '0;
            tcol_reg <= '0;
            trow_reg <= '0;
            pend_reg <= '0;
            emit_reg <= 1'b0;
            ov_reg   <= 1'b0;
            for (int k = 0; k < 3; k++)
                for (int j = 0; j < 3; j++)
                    pw_reg[k][j] <= '0;
            for (int k = 0; k < 5; k++)
            begin
                pxx_reg[k] <= '0;
                pyy_reg[k] <= '0;
                pxy_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.op == OP_LOAD)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH, REG_FRAME_HEIGHT:
                    begin
                        if (cfg_index == REG_FRAME_WIDTH)
                            w_reg <= DW'(clamp_dim(cfg_data[11:0], MAX_WIDTH));
                        else
                            h_reg <= HW'(clamp_dim(cfg_data[11:0], MAX_HEIGHT));
                        col_reg  <= '0;
                        row_reg  <= '0;
                        tcol_reg <= '0;
                        trow_reg <= '0;
                        pend_reg <= '0;
                    end
                    REG_MIN_EIGEN: thr_reg <= cfg_data[15:0];
                    REG_RESP_DIV:  div_reg <= cfg_data;
                    default:       thr_reg <= thr_reg;
                endcase
            end
            else
            begin
                case (cmd.op)
                    OP_ACCEPT:
                    begin
                        if (in_flush && pend_reg != '0)
                        begin
                            pend_reg <= pend_reg - 1'b1;
                            tcol_reg <= tcol_adv;
                            trow_reg <= trow_adv;
                        end
                    end
                    OP_WIN:
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            pw_reg[k][0] <= pw_reg[k][1];
                            pw_reg[k][1] <= pw_reg[k][2];
                        end
                        pw_reg[0][2] <= up2_reg;
                        pw_reg[1][2] <= up1_reg;
                        pw_reg[2][2] <= pix_reg;
                    end
                    OP_PROD:
                    begin
                        for (int k = 0; k < 4; k++)
                        begin
                            pxx_reg[k] <= pxx_reg[k+1];
                            pyy_reg[k] <= pyy_reg[k+1];
                            pxy_reg[k] <= pxy_reg[k+1];
                        end
                        pxx_reg[4] <= 28'(gxx_w);
                        pyy_reg[4] <= 28'(gyy_w);
                        pxy_reg[4] <= 29'(gxy_w);
                    end
                    OP_SUM:
                    begin
                        col_reg  <= col_adv;
                        row_reg  <= row_adv;
                        emit_reg <= (pend_reg == lag);
                        if (pend_reg != lag)
                            pend_reg <= pend_reg + 1'b1;
                        else
                        begin
                            tcol_reg <= tcol_adv;
                            trow_reg <= trow_adv;
                        end
                    end
                    default: emit_reg <= emit_reg;
                endcase
            end
        end
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_ACCEPT)
        begin
            up1_reg   <= pix1_mem[col_reg];
            up2_reg   <= pix2_mem[col_reg];
            rs_reg[0] <= hs0_mem[col_reg];
            rs_reg[1] <= hs1_mem[col_reg];
            rs_reg[2] <= hs2_mem[col_reg];
            rs_reg[3] <= hs3_mem[col_reg];
        end
        if (cmd.op == OP_WIN)
        begin
            pix2_mem[col_reg] <= up1_reg;
            pix1_mem[col_reg] <= pix_reg;
        end
        if (cmd.op == OP_SUM)
        begin
            hs3_mem[col_reg] <= rs_reg[2];
            hs2_mem[col_reg] <= rs_reg[1];
            hs1_mem[col_reg] <= rs_reg[0];
            hs0_mem[col_reg] <= {hxy_reg, hyy_reg, hxx_reg};
        end
    end

    // arithmetic payload
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACCEPT:
            begin
                pix_reg <= in_pixel;
                res_row_reg  <= 11'(trow_reg);
                res_col_reg  <= 11'(tcol_reg);
                res_end_reg  <= tend_w;
                res_resp_reg <= '0;
            end
            OP_GRAD:
            begin
                gx_reg <= gx_w;
                gy_reg <= gy_w;
            end
            OP_HSUM:
            begin
                hxx_reg <= hxx_w;
                hyy_reg <= hyy_w;
                hxy_reg <= hxy_w;
            end
            OP_SUM:
            begin
                sxx_reg      <= sxx_w;
                syy_reg      <= syy_w;
                sxy_reg      <= sxy_w;
                interior_reg <= interior_w;
                res_row_reg  <= 11'(trow_reg);
                res_col_reg  <= 11'(tcol_reg);
                res_end_reg  <= tend_w;
                res_resp_reg <= '0;
            end
            OP_PREP:
            begin
                a_reg  <= sxx_reg;
                d_reg  <= syy_reg;
                bm_reg <= 35'((sxy_reg < 0) ? -sxy_reg : sxy_reg);
                tr_reg <= 36'(sxx_reg) + 36'(syy_reg);
                ts_reg <= 34'(thr_reg) * 34'(SCALE);
            end
            OP_MUL_STORE:
            begin
                case (cmd.sel)
                    MUL_AD:   ad_reg <= mul_p[69:0];
                    MUL_BB:   det_reg <= (ad_reg >= mul_p[69:0]) ? ad_reg - mul_p[69:0] : '0;
                    MUL_TRTS: trts_reg <= mul_p[69:0];
                    MUL_TSTS: tsts_reg <= mul_p[67:0];
                    MUL_DIV:  dd_reg <= mul_p[66:0];
                    default:  dd_reg <= dd_reg;
                endcase
            end
            OP_CMP:
            begin
                ok_reg <= ({1'b0, ts_reg, 1'b0} < tr_reg) && ({1'b0, trts_reg} < rhs_w);
            end
            OP_DIVINIT:
            begin
                rem_reg <= det_reg;
                dsh_reg <= 79'(dd_reg) << (DIV_STEPS - 1);
                sat_reg <= 79'(det_reg) >= (79'(dd_reg) << DIV_STEPS);
                q_reg   <= '0;
            end
            OP_DIV_STEP:
            begin
                if (79'(rem_reg) >= dsh_reg)
                begin
                    rem_reg <= rem_reg - dsh_reg[69:0];
                    q_reg   <= {q_reg[10:0], 1'b1};
                end
                else
                    q_reg <= {q_reg[10:0], 1'b0};
                dsh_reg <= dsh_reg >> 1;
            end
            OP_FIN:
                res_resp_reg <= ok_reg ? (sat_reg ? RESP_MAX : q_reg) : '0;
            OP_LOAD:
            begin
                orow_reg  <= res_row_reg;
                ocol_reg  <= res_col_reg;
                oresp_reg <= res_resp_reg;
                oend_reg  <= res_end_reg;
            end
            default: q_reg <= q_reg;
        endcase
    end

    assign status.pending_zero = (pend_reg == '0);
    assign status.emit         = emit_reg;
    assign status.interior     = interior_reg;
    assign status.mul_busy     = mul_busy;
    assign status.out_free     = !ov_reg || out_ready;

    assign out_valid  = ov_reg;
    assign out_row    = orow_reg;
    assign out_column = ocol_reg;
    assign response   = oresp_reg;
    assign frame_end  = oend_reg;

endmodule

// ----- rtl/crps_ctrl.sv -----
// Controller state machine: sequences one transaction through the datapath.
// Depends on crps_pkg for state, command and status types.
`timescale 1ns / 1ps

module crps_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_flush,
    output logic                 in_ready,
    input  crps_pkg::dp_status_t status,
    output crps_pkg::dp_cmd_t    cmd
);
    import crps_pkg::*;

    ctrl_state_t state_reg, state_next;
    mul_sel_t    sel_reg, sel_next;
    logic [3:0]  cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= MUL_AD;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        cmd.sel    = sel_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = OP_ACCEPT;
                    if (!in_flush)
                        state_next = S_WIN;
                    else if (!status.pending_zero)
                        state_next = S_LOAD;
                end
            end
            S_WIN:
            begin
                cmd.op = OP_WIN;
                state_next = S_GRAD;
            end
            S_GRAD:
            begin
                cmd.op = OP_GRAD;
                state_next = S_PROD;
            end
            S_PROD:
            begin
                cmd.op = OP_PROD;
                state_next = S_HSUM;
            end
            S_HSUM:
            begin
                cmd.op = OP_HSUM;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.op = OP_SUM;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (!status.emit)
                    state_next = S_IDLE;
                else if (!status.interior)
                    state_next = S_LOAD;
                else
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.op = OP_PREP;
                sel_next = MUL_AD;
                state_next = S_MSTART;
            end
            S_MSTART:
            begin
                cmd.op = OP_MUL_START;
                state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (!status.mul_busy)
                begin
                    cmd.op = OP_MUL_STORE;
                    state_next = S_MSTART;
                    case (sel_reg)
                        MUL_AD:   sel_next = MUL_BB;
                        MUL_BB:   sel_next = MUL_TRTS;
                        MUL_TRTS: sel_next = MUL_TSTS;
                        MUL_TSTS: sel_next = MUL_DIV;
                        default:  state_next = S_CMP;
                    endcase
                end
            end
            S_CMP:
            begin
                cmd.op = OP_CMP;
                state_next = S_DIVINIT;
            end
            S_DIVINIT:
            begin
                cmd.op = OP_DIVINIT;
                cnt_next = 4'(DIV_STEPS - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (cnt_reg == '0)
                    state_next = S_FIN;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_FIN:
            begin
                cmd.op = OP_FIN;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.op = OP_LOAD;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/corner_response_pixel_stream.sv -----
// Top level of the corner response pixel stream block.
// Depends on crps_pkg, crps_ctrl and crps_datapath (which holds crps_mul).
`timescale 1ns / 1ps

// Corner strength over a raster pixel stream.
//
// Slave stream: one transaction per pixel, or a flush (tuser high) that
// drains the oldest pending position with response zero. Master stream: one
// result per transaction at most, tagged with its row and column; tlast
// marks the last pixel of the frame. Configuration: write frame width,
// height, eigenvalue threshold and divisor by index; a width or height
// write restarts the stream and drops pending results.
//
// Results trail their pixels by three lines plus three pixels.
// One transaction at a time. A pixel whose result is not yet due returns to
// idle after the filter states; a border result goes straight to the output;
// an interior pixel runs five 36-step products through the bit-serial
// multiplier and a 12-step divider that forms the saturated quotient. A
// flush goes to the output only when something is pending.
//
// After reset the frame is 640 by 480, nothing is pending and the line
// stores hold no data until written (they reach only border positions).
// The output register holds a result while the receiver stalls; the next
// transaction is taken meanwhile and waits only when its own result is due.
module corner_response_pixel_stream #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] pixel, [15:12] zero
    input  logic        s_axis_tuser,   // [0] mode: high for flush
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [10:0] out_row, [21:11] out_column,
                                        // [33:22] response, [39:34] zero
    output logic        m_axis_tlast,   // frame_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import crps_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [10:0] out_row, out_column;
    logic [11:0] response;

    // the user must write configuration only while idle; the block does not enforce it, so always take it
    assign cfg_ready = 1'b1;

    crps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_flush (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    crps_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_flush   (s_axis_tuser),
        .in_pixel   (s_axis_tdata[11:0]),
        .cfg_we     (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_row    (out_row),
        .out_column (out_column),
        .response   (response),
        .frame_end  (m_axis_tlast)
    );

    // pack fields from the lowest bit up, zero fill to whole bytes
    assign m_axis_tdata = {6'd0, response, out_column, out_row};

endmodule
